### src/kced_pkg.sv
// Package for the key click event detector: flag encoding, click phase codes,
// action codes and configuration register indexes. No dependencies.
package kced_pkg;

    // Fixed field widths.
    localparam int LEVEL_W   = 4;
    localparam int KEY_IDX_W = 2;
    localparam int FLAG_W    = 7;
    localparam int TIMER_W   = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;
    // Width used to compare a key number against a loop index (up to 64 keys).
    localparam int KEY_CMP_W = 6;

    // Event flag bit positions.
    localparam int FLG_HOLD   = 0;
    localparam int FLG_DOWN   = 1;
    localparam int FLG_UP     = 2;
    localparam int FLG_SINGLE = 3;
    localparam int FLG_DOUBLE = 4;
    localparam int FLG_LONG   = 5;
    localparam int FLG_REPEAT = 6;

    // A check mask of exactly the hold flag reads without clearing.
    localparam logic [FLAG_W-1:0] HOLD_ONLY_MASK = 7'b000_0001;

    // Item actions.
    localparam logic ACT_TICK  = 1'b0;
    localparam logic ACT_CHECK = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_HIGH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DOUBLE_WINDOW = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_TIME     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_TIME   = 2'd3;

    // Configuration reset values.
    localparam logic [LEVEL_W-1:0] ACTIVE_HIGH_RST   = 4'd12;
    localparam logic [TIMER_W-1:0] DOUBLE_WINDOW_RST = 16'd10;
    localparam logic [TIMER_W-1:0] LONG_TIME_RST     = 16'd100;
    localparam logic [TIMER_W-1:0] REPEAT_TIME_RST   = 16'd50;

    // Per-key click phase.
    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_DOWN   = 3'd1,
        PH_WAIT   = 3'd2,
        PH_SECOND = 3'd3,
        PH_REPEAT = 3'd4
    } phase_t;

endpackage

### src/key_click_event_detector.sv
// Top level of the key click event detector: input register, per-key click
// state machines and flag logic, result register. Depends on kced_pkg.

// Each accepted item is held in an input register and handled once the output
// register is free, when its result is loaded into the output register. One
// item is taken in every cycle as long as results are taken: the only limit
// is the single pass of per-key logic between the input register and the
// output register. A tick item (action 0) samples all keys, counts down the
// per-key timers and steps each key's click machine; its result is always
// hit 0 and flags 0. A check item (action 1) returns the flags of one key and
// whether any masked flag is set, and clears the masked flags unless the mask
// is exactly the hold flag.
// Configuration writes take effect at once and are meant for idle periods.
module key_click_event_detector #(
    parameter int NUM_KEYS = 4
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // Configuration write port
    input  logic                                 cfg_write,
    input  logic [kced_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [kced_pkg::CFG_DATA_W-1:0]      cfg_data,
    // Input channel
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic                                 action,
    input  logic [kced_pkg::LEVEL_W-1:0]         key_levels,
    input  logic [kced_pkg::KEY_IDX_W-1:0]       key_index,
    input  logic [kced_pkg::FLAG_W-1:0]          event_mask,
    // Output channel
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic                                 hit,
    output logic [kced_pkg::FLAG_W-1:0]          selected_flags
);

    localparam int FW = kced_pkg::FLAG_W;
    localparam int TW = kced_pkg::TIMER_W;

    // Configuration registers
    logic [kced_pkg::LEVEL_W-1:0] active_high_reg;
    logic [TW-1:0]                double_window_reg;
    logic [TW-1:0]                long_time_reg;
    logic [TW-1:0]                repeat_time_reg;

    // Input register
    logic                               in_valid_reg;
    logic                               action_reg;
    logic [kced_pkg::LEVEL_W-1:0]       key_levels_reg;
    logic [kced_pkg::KEY_IDX_W-1:0]     key_index_reg;
    logic [FW-1:0]                      event_mask_reg;

    // Output register
    logic          out_valid_reg;
    logic          hit_reg;
    logic [FW-1:0] selected_flags_reg;

    // Per-key state
    kced_pkg::phase_t phase_reg   [NUM_KEYS];
    kced_pkg::phase_t phase_next  [NUM_KEYS];
    logic [TW-1:0]    timer_reg   [NUM_KEYS];
    logic [TW-1:0]    timer_next  [NUM_KEYS];
    logic [FW-1:0]    flags_reg   [NUM_KEYS];
    logic [FW-1:0]    flags_next  [NUM_KEYS];
    logic [NUM_KEYS-1:0] pressed_reg;
    logic [NUM_KEYS-1:0] pressed_now;
    logic [NUM_KEYS-1:0] key_match;

    logic          out_ready;
    logic          go;
    logic          tick_go;
    logic          chk_go;
    logic [FW-1:0] sel_flags;
    logic          sel_hit;
    logic          clear_ok;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_high_reg   <= kced_pkg::ACTIVE_HIGH_RST;
            double_window_reg <= kced_pkg::DOUBLE_WINDOW_RST;
            long_time_reg     <= kced_pkg::LONG_TIME_RST;
            repeat_time_reg   <= kced_pkg::REPEAT_TIME_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                kced_pkg::CFG_ACTIVE_HIGH:
                    active_high_reg <= cfg_data[kced_pkg::LEVEL_W-1:0];
                kced_pkg::CFG_DOUBLE_WINDOW: double_window_reg <= cfg_data;
                kced_pkg::CFG_LONG_TIME:     long_time_reg     <= cfg_data;
                kced_pkg::CFG_REPEAT_TIME:   repeat_time_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // Flow control: the held item moves on when the output register is free.
    assign out_ready = !out_valid_reg || !out_stall;
    assign go        = in_valid_reg && out_ready;
    assign tick_go   = go && (action_reg == kced_pkg::ACT_TICK);
    assign chk_go    = go && (action_reg == kced_pkg::ACT_CHECK);
    assign in_stall  = in_valid_reg && !out_ready;

    // Input register: loaded on each input transfer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_valid && !in_stall)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (go)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            action_reg     <= action;
            key_levels_reg <= key_levels;
            key_index_reg  <= key_index;
            event_mask_reg <= event_mask;
        end
    end

    // Select the flags of the key named by a check item.
    always_comb
    begin
        sel_flags = '0;
        for (int k = 0; k < NUM_KEYS; k++)
        begin
            key_match[k] = (kced_pkg::KEY_CMP_W'(key_index_reg) ==
                            kced_pkg::KEY_CMP_W'(k));
            if (key_match[k])
            begin
                sel_flags = flags_reg[k];
            end
        end
    end

    assign sel_hit  = |(sel_flags & event_mask_reg);
    assign clear_ok = sel_hit && (event_mask_reg != kced_pkg::HOLD_ONLY_MASK);

    // Per-key sampling, timer, click machine and flags.
    for (genvar k = 0; k < NUM_KEYS; k++)
    begin : g_key
        logic          lvl;
        logic          pol;
        logic [TW-1:0] timer_dec;
        logic          evt_long;
        logic          evt_repeat;
        logic          evt_single;
        logic          evt_double;

        // Keys without a level bit read level 0 with active-low polarity.
        if (k < kced_pkg::LEVEL_W)
        begin : g_pin
            assign lvl = key_levels_reg[k];
            assign pol = active_high_reg[k];
        end
        else
        begin : g_nopin
            assign lvl = 1'b0;
            assign pol = 1'b0;
        end

        assign pressed_now[k] = (lvl == pol);
        assign timer_dec = (timer_reg[k] != '0) ? timer_reg[k] - TW'(1) : timer_reg[k];

        // Next phase and timer on a tick.
        always_comb
        begin
            phase_next[k] = phase_reg[k];
            timer_next[k] = timer_reg[k];
            if (tick_go)
            begin
                timer_next[k] = timer_dec;
                case (phase_reg[k])
                    kced_pkg::PH_IDLE:
                    begin
                        if (pressed_now[k])
                        begin
                            timer_next[k] = long_time_reg;
                            phase_next[k] = kced_pkg::PH_DOWN;
                        end
                    end
                    kced_pkg::PH_DOWN:
                    begin
                        if (!pressed_now[k])
                        begin
                            timer_next[k] = double_window_reg;
                            phase_next[k] = kced_pkg::PH_WAIT;
                        end
                        else if (timer_dec == '0)
                        begin
                            timer_next[k] = repeat_time_reg;
                            phase_next[k] = kced_pkg::PH_REPEAT;
                        end
                    end
                    kced_pkg::PH_WAIT:
                    begin
                        if (pressed_now[k])
                        begin
                            phase_next[k] = kced_pkg::PH_SECOND;
                        end
                        else if (timer_dec == '0)
                        begin
                            phase_next[k] = kced_pkg::PH_IDLE;
                        end
                    end
                    kced_pkg::PH_SECOND:
                    begin
                        if (!pressed_now[k])
                        begin
                            phase_next[k] = kced_pkg::PH_IDLE;
                        end
                    end
                    kced_pkg::PH_REPEAT:
                    begin
                        if (!pressed_now[k])
                        begin
                            phase_next[k] = kced_pkg::PH_IDLE;
                        end
                        else if (timer_dec == '0)
                        begin
                            timer_next[k] = repeat_time_reg;
                        end
                    end
                    default:
                    begin
                        phase_next[k] = kced_pkg::PH_IDLE;
                    end
                endcase
            end
        end

        // Click events raised by the phase machine.
        always_comb
        begin
            evt_long   = 1'b0;
            evt_repeat = 1'b0;
            evt_single = 1'b0;
            evt_double = 1'b0;
            case (phase_reg[k])
                kced_pkg::PH_DOWN:
                    evt_long = pressed_now[k] && (timer_dec == '0);
                kced_pkg::PH_WAIT:
                begin
                    evt_double = pressed_now[k];
                    evt_single = !pressed_now[k] && (timer_dec == '0);
                end
                kced_pkg::PH_REPEAT:
                    evt_repeat = pressed_now[k] && (timer_dec == '0);
                default: ;
            endcase
        end

        // Flags: set by ticks (the hold flag follows the key), cleared by matching checks.
        always_comb
        begin
            flags_next[k] = flags_reg[k];
            if (tick_go)
            begin
                flags_next[k][kced_pkg::FLG_HOLD] = pressed_now[k];
                if (pressed_now[k] && !pressed_reg[k])
                begin
                    flags_next[k][kced_pkg::FLG_DOWN] = 1'b1;
                end
                if (!pressed_now[k] && pressed_reg[k])
                begin
                    flags_next[k][kced_pkg::FLG_UP] = 1'b1;
                end
                if (evt_long)
                begin
                    flags_next[k][kced_pkg::FLG_LONG] = 1'b1;
                end
                if (evt_repeat)
                begin
                    flags_next[k][kced_pkg::FLG_REPEAT] = 1'b1;
                end
                if (evt_single)
                begin
                    flags_next[k][kced_pkg::FLG_SINGLE] = 1'b1;
                end
                if (evt_double)
                begin
                    flags_next[k][kced_pkg::FLG_DOUBLE] = 1'b1;
                end
            end
            else if (chk_go && key_match[k] && clear_ok)
            begin
                flags_next[k] = flags_reg[k] & ~event_mask_reg;
            end
        end

        // Per-key state registers.
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                phase_reg[k]   <= kced_pkg::PH_IDLE;
                timer_reg[k]   <= '0;
                flags_reg[k]   <= '0;
                pressed_reg[k] <= 1'b0;
            end
            else
            begin
                phase_reg[k] <= phase_next[k];
                timer_reg[k] <= timer_next[k];
                flags_reg[k] <= flags_next[k];
                if (tick_go)
                begin
                    pressed_reg[k] <= pressed_now[k];
                end
            end
        end
    end

    // Output register: one result per item; a tick reports hit 0 and no flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (go)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            hit_reg            <= chk_go && sel_hit;
            selected_flags_reg <= chk_go ? sel_flags : '0;
        end
    end

    assign out_valid      = out_valid_reg;
    assign hit            = hit_reg;
    assign selected_flags = selected_flags_reg;

`ifndef SYNTH
    // A hit can only come from a key with some flag set.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && hit |-> selected_flags != '0)
        else $error("hit reported with no flag set");

    // A held item always reaches an empty output register in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !out_valid_reg |=> out_valid_reg)
        else $error("held item did not reach the output register");

    for (genvar k = 0; k < NUM_KEYS; k++)
    begin : g_chk
        // Phases that follow a press imply the key was last seen pressed.
        assert property (@(posedge clk) disable iff (!rst_n)
            (phase_reg[k] == kced_pkg::PH_DOWN) || (phase_reg[k] == kced_pkg::PH_SECOND) ||
            (phase_reg[k] == kced_pkg::PH_REPEAT) |-> pressed_reg[k])
            else $error("pressed phase with key released");

        // Waiting for a second press implies the key was last seen released.
        assert property (@(posedge clk) disable iff (!rst_n)
            phase_reg[k] == kced_pkg::PH_WAIT |-> !pressed_reg[k])
            else $error("wait phase with key pressed");
    end
`endif

endmodule
